>>> rtl/core/cpcq_pkg.sv
// Shared types and opcodes for the class priority command queue.
package cpcq_pkg;

	localparam logic [2:0] OP_ENQ_NORMAL = 3'd0;
	localparam logic [2:0] OP_ENQ_SAFETY = 3'd1;
	localparam logic [2:0] OP_ENQ_FOLLOW = 3'd2;
	localparam logic [2:0] OP_POP        = 3'd3;
	localparam logic [2:0] OP_CANCEL     = 3'd4;

	typedef struct packed {
		logic [7:0]  op;
		logic [63:0] value;
		logic [11:0] key;
		logic        rd;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_CHK,
		ST_DEC,
		ST_SHIFT,
		ST_SHIFT_WR,
		ST_INS,
		ST_INS_WR,
		ST_CAN,
		ST_CAN_CHK,
		ST_POP,
		ST_POP_CHK,
		ST_DONE
	} state_t;

endpackage

>>> rtl/core/cpcq_ram.sv
// Synchronous single-port-write, single-port-read entry memory.
module cpcq_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  cpcq_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output cpcq_pkg::entry_t rdata
);

	cpcq_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/class_priority_command_queue.sv
// Top level of the class priority command queue with dedup.
//
// Items enter on the valid/ready input channel: opcode, command fields, dedup key and
// read flag. Every item yields exactly one result beat on the output channel with the
// acceptance flag, the popped entry, the entry count and the overflow total.
// Entries live in one synchronous memory; a sequencer scans, shifts and writes it.
// Scanning an entry takes a read and a compare state; moving an entry takes a read and a
// write state. An enqueue scans the queued entries for its key until a match, moves each
// entry between its slot and the tail up by one and stores itself; at the tail none are
// moved, and when full it is rejected and counted as an overflow. A key match first
// removes the match and moves the entries behind it down to close the gap. A pop
// removes the head and closes the gap; on an empty queue it goes straight to the result,
// as do unused opcodes. A cancel examines entries, closing the gap at each one it removes.
// The result beat is offered the cycle after the work ends and held until taken.
// One item is worked at a time; ready is high only while the sequencer is idle, so it
// returns the cycle after the result beat is taken, and a stalled receiver blocks input.
// Reset clears the counts and the overflow total; memory contents are not cleared.
module class_priority_command_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [7:0]  command_op,
	input  logic [63:0] command_value,
	input  logic [11:0] dedup_key,
	input  logic        is_read,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [7:0]  popped_op,
	output logic [63:0] popped_value,
	output logic        popped_is_read,
	output logic [4:0]  entry_count,
	output logic [31:0] overflow_total
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	cpcq_pkg::state_t state_q, state_d;

	logic [CW-1:0] used_q, safe_q, foll_q, idx_q, pos_q;
	logic [31:0]   ovf_q;
	logic [2:0]    opc_q;
	cpcq_pkg::entry_t new_q, rdata, wdata;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic          ok_q;

	cpcq_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [CW-1:0] ins_pos;
	always_comb begin
		if (opc_q == cpcq_pkg::OP_ENQ_SAFETY) begin
			ins_pos = safe_q;
		end else if (opc_q == cpcq_pkg::OP_ENQ_FOLLOW) begin
			ins_pos = safe_q + foll_q;
		end else begin
			ins_pos = used_q;
		end
		if (ins_pos > used_q) begin
			ins_pos = used_q;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cpcq_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (opcode)
						cpcq_pkg::OP_ENQ_NORMAL, cpcq_pkg::OP_ENQ_SAFETY,
						cpcq_pkg::OP_ENQ_FOLLOW: state_d = cpcq_pkg::ST_SCAN;
						cpcq_pkg::OP_POP:        state_d = cpcq_pkg::ST_POP;
						cpcq_pkg::OP_CANCEL:     state_d = cpcq_pkg::ST_CAN;
						default:                 state_d = cpcq_pkg::ST_DONE;
					endcase
				end
			end
			cpcq_pkg::ST_SCAN:
				state_d = (idx_q < used_q) ? cpcq_pkg::ST_SCAN_CHK : cpcq_pkg::ST_INS;
			cpcq_pkg::ST_SCAN_CHK:
				state_d = (rdata.key == new_q.key) ? cpcq_pkg::ST_DEC : cpcq_pkg::ST_SCAN;
			cpcq_pkg::ST_DEC:      state_d = cpcq_pkg::ST_SHIFT;
			cpcq_pkg::ST_SHIFT: begin
				// Close the gap at idx_q by pulling idx_q+1 down.
				if (idx_q < used_q) begin
					state_d = cpcq_pkg::ST_SHIFT_WR;
				end else begin
					state_d = (opc_q == cpcq_pkg::OP_CANCEL) ? cpcq_pkg::ST_CAN
						: (opc_q == cpcq_pkg::OP_POP) ? cpcq_pkg::ST_DONE
						: cpcq_pkg::ST_INS;
				end
			end
			cpcq_pkg::ST_SHIFT_WR: state_d = cpcq_pkg::ST_SHIFT;
			cpcq_pkg::ST_INS: begin
				if (used_q >= DEPTH_C || idx_q <= ins_pos) begin
					state_d = cpcq_pkg::ST_DONE;
				end else begin
					state_d = cpcq_pkg::ST_INS_WR;
				end
			end
			cpcq_pkg::ST_INS_WR:   state_d = cpcq_pkg::ST_INS;
			cpcq_pkg::ST_CAN:
				state_d = (pos_q < used_q) ? cpcq_pkg::ST_CAN_CHK : cpcq_pkg::ST_DONE;
			cpcq_pkg::ST_CAN_CHK:
				state_d = rdata.rd ? cpcq_pkg::ST_CAN : cpcq_pkg::ST_DEC;
			cpcq_pkg::ST_POP:
				state_d = (used_q != '0) ? cpcq_pkg::ST_POP_CHK : cpcq_pkg::ST_DONE;
			cpcq_pkg::ST_POP_CHK:  state_d = cpcq_pkg::ST_DEC;
			cpcq_pkg::ST_DONE:     if (out_ready) state_d = cpcq_pkg::ST_IDLE;
			default:               state_d = cpcq_pkg::ST_IDLE;
		endcase
	end

	// Memory access and handshake outputs.
	always_comb begin
		in_ready  = (state_q == cpcq_pkg::ST_IDLE);
		out_valid = (state_q == cpcq_pkg::ST_DONE);
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		case (state_q)
			cpcq_pkg::ST_SHIFT:    raddr = AW'(idx_q + 1'b1);
			cpcq_pkg::ST_SHIFT_WR: we = 1'b1;
			cpcq_pkg::ST_INS_WR:   we = 1'b1;
			cpcq_pkg::ST_CAN:      raddr = pos_q[AW-1:0];
			cpcq_pkg::ST_POP:      raddr = '0;
			cpcq_pkg::ST_INS: begin
				// idx_q walks down from used_q; each step moves one entry up.
				if (used_q < DEPTH_C) begin
					if (idx_q > ins_pos) begin
						raddr = AW'(idx_q - 1'b1);
					end else begin
						we    = 1'b1;
						wdata = new_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= cpcq_pkg::ST_IDLE;
			used_q         <= '0;
			safe_q         <= '0;
			foll_q         <= '0;
			ovf_q          <= '0;
			idx_q          <= '0;
			pos_q          <= '0;
			ok_q           <= 1'b0;
			popped_op      <= '0;
			popped_value   <= '0;
			popped_is_read <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				cpcq_pkg::ST_IDLE: begin
					if (in_valid) begin
						idx_q          <= '0;
						pos_q          <= '0;
						ok_q           <= 1'b0;
						popped_op      <= '0;
						popped_value   <= '0;
						popped_is_read <= 1'b0;
					end
				end
				cpcq_pkg::ST_SCAN_CHK: begin
					if (rdata.key != new_q.key) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				cpcq_pkg::ST_DEC: begin
					if (idx_q < safe_q) begin
						safe_q <= safe_q - 1'b1;
					end else if (idx_q < safe_q + foll_q) begin
						foll_q <= foll_q - 1'b1;
					end
					used_q <= used_q - 1'b1;
				end
				cpcq_pkg::ST_SHIFT_WR: idx_q <= idx_q + 1'b1;
				cpcq_pkg::ST_INS: begin
					if (used_q >= DEPTH_C) begin
						if (ovf_q != '1) begin
							ovf_q <= ovf_q + 1'b1;
						end
					end else if (idx_q <= ins_pos) begin
						ok_q   <= 1'b1;
						used_q <= used_q + 1'b1;
						if (opc_q == cpcq_pkg::OP_ENQ_SAFETY) begin
							safe_q <= safe_q + 1'b1;
						end else if (opc_q == cpcq_pkg::OP_ENQ_FOLLOW) begin
							foll_q <= foll_q + 1'b1;
						end
					end
				end
				cpcq_pkg::ST_INS_WR:   idx_q <= idx_q - 1'b1;
				cpcq_pkg::ST_CAN_CHK: begin
					if (rdata.rd) begin
						pos_q <= pos_q + 1'b1;
					end else begin
						idx_q <= pos_q;
					end
				end
				cpcq_pkg::ST_POP_CHK: begin
					ok_q           <= 1'b1;
					popped_op      <= rdata.op;
					popped_value   <= rdata.value;
					popped_is_read <= rdata.rd;
					idx_q          <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cpcq_pkg::ST_IDLE && in_valid) begin
			opc_q <= opcode;
			new_q <= '{op: command_op, value: command_value, key: dedup_key, rd: is_read};
		end
	end

	assign accepted       = ok_q;
	assign entry_count    = 5'(used_q);
	assign overflow_total = ovf_q;

endmodule
